### sv/tlgc_pkg.sv
// Shared types and constants for the two-leaf gate controller.
// No dependencies; every other file refers to this package by scoped names.
package tlgc_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_PUSH_MIN      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PUSH_MAX      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REMOTE_MIN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTACT_TICKS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRAVEL_LIMIT  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_TICK_DIV = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_DIV     = 3'd7;

    localparam logic [7:0] RST_PUSH_MIN      = 8'd10;
    localparam logic [7:0] RST_PUSH_MAX      = 8'd150;
    localparam logic [7:0] RST_HOLD_TICKS    = 8'd200;
    localparam logic [9:0] RST_REMOTE_MIN    = 10'd10;
    localparam logic [2:0] RST_CONTACT_TICKS = 3'd5;
    localparam logic [7:0] RST_TRAVEL_LIMIT  = 8'd250;
    localparam logic [3:0] RST_SLOW_TICK_DIV = 4'd10;
    localparam logic [2:0] RST_FLASH_DIV     = 3'd5;

    localparam logic [9:0] REMOTE_SAT    = 10'd1000;
    localparam logic [3:0] PRESCALE_SAT  = 4'd15;
    localparam logic [2:0] FLASH_SAT     = 3'd7;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_RUN    = 2'd1,
        MODE_MANUAL = 2'd2,
        MODE_WAIT   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0] push_min;
        logic [7:0] push_max;
        logic [7:0] hold_ticks;
        logic [9:0] remote_min;
        logic [2:0] contact_ticks;
        logic [7:0] travel_limit;
        logic [3:0] slow_tick_div;
        logic [2:0] flash_div;
    } t_cfg;

    typedef struct packed {
        logic push_seen;
        logic hold_seen;
        logic remote_seen;
        logic contact_a;
        logic contact_b;
    } t_deb;

    typedef struct packed {
        logic       motor_a_on;
        logic       motor_b_on;
        logic       close_direction;
        logic       line_a;
        logic       line_b;
        logic       indicator;
        logic [1:0] mode;
        logic       gate_closed;
        logic       is_opening;
        logic       is_closing;
    } t_result;

endpackage

### sv/tlgc_debounce.sv
// Debouncing of the gate button, remote contact and both reed contacts.
// Depends on tlgc_pkg for the configuration and flag structures.
module tlgc_debounce (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  tlgc_pkg::t_cfg i_cfg,
    input  logic          i_button_level,
    input  logic          i_remote_level,
    input  logic          i_reed_a_level,
    input  logic          i_reed_b_level,
    input  logic          i_clr_push,
    output tlgc_pkg::t_deb o_flags
);

    logic [7:0]   r_press, n_press;
    logic [9:0]   r_remote, n_remote;
    logic [2:0]   r_reed_a, n_reed_a;
    logic [2:0]   r_reed_b, n_reed_b;
    tlgc_pkg::t_deb r_flags, n_flags;

    always_comb begin
        n_flags  = r_flags;
        n_press  = r_press;
        n_remote = r_remote;
        n_reed_a = r_reed_a;
        n_reed_b = r_reed_b;

        if (!i_button_level) begin
            if (r_press < i_cfg.hold_ticks) begin
                n_press = r_press + 8'd1;
            end
            if (n_press == i_cfg.hold_ticks) begin
                n_flags.hold_seen = 1'b1;
            end
        end else begin
            if (r_press > i_cfg.push_min && r_press < i_cfg.push_max) begin
                n_flags.push_seen = 1'b1;
            end else begin
                n_flags.hold_seen = 1'b0;
            end
            n_press = 8'd0;
        end

        if (!i_remote_level) begin
            if (r_remote < tlgc_pkg::REMOTE_SAT) begin
                n_remote = r_remote + 10'd1;
            end
        end else begin
            if (r_remote > i_cfg.remote_min) begin
                n_flags.remote_seen = 1'b1;
            end
            n_remote = 10'd0;
        end

        if (!i_reed_a_level) begin
            if (r_reed_a < i_cfg.contact_ticks) begin
                n_reed_a = r_reed_a + 3'd1;
                if (n_reed_a == i_cfg.contact_ticks) begin
                    n_flags.contact_a = 1'b1;
                end
            end
        end else begin
            n_flags.contact_a = 1'b0;
            n_reed_a          = 3'd0;
        end

        if (!i_reed_b_level) begin
            if (r_reed_b < i_cfg.contact_ticks) begin
                n_reed_b = r_reed_b + 3'd1;
                if (n_reed_b == i_cfg.contact_ticks) begin
                    n_flags.contact_b = 1'b1;
                end
            end
        end else begin
            n_flags.contact_b = 1'b0;
            n_reed_b          = 3'd0;
        end
    end

    assign o_flags = n_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press  <= 8'd0;
            r_remote <= 10'd0;
            r_reed_a <= 3'd0;
            r_reed_b <= 3'd0;
            r_flags  <= '0;
        end else if (i_adv) begin
            r_press  <= n_press;
            r_remote <= n_remote;
            r_reed_a <= n_reed_a;
            r_reed_b <= n_reed_b;
            r_flags  <= {n_flags.push_seen & ~i_clr_push, n_flags.hold_seen,
                         n_flags.remote_seen & ~i_clr_push, n_flags.contact_a,
                         n_flags.contact_b};
        end
    end

endmodule

### sv/tlgc_ctrl.sv
// Leaf controller: slow-tick prescaler, indicator blink, travel timer and
// the idle, running, manual and wait modes. Depends on tlgc_pkg.
module tlgc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  tlgc_pkg::t_cfg    i_cfg,
    input  tlgc_pkg::t_deb    i_flags,
    output logic              o_clr_push,
    output tlgc_pkg::t_result o_result
);

    tlgc_pkg::t_mode r_mode, n_mode;
    logic       r_opening, n_opening;
    logic       r_closing, n_closing;
    logic       r_closed, n_closed;
    logic       r_run_a, n_run_a;
    logic       r_run_b, n_run_b;
    logic       r_dir, n_dir;
    logic       r_line_a, n_line_a;
    logic       r_line_b, n_line_b;
    logic       r_ind, n_ind;
    logic       r_active, n_active;
    logic [3:0] r_prescale, n_prescale;
    logic [2:0] r_flash, n_flash;
    logic [7:0] r_travel, n_travel;

    always_comb begin
        logic v_push;
        logic v_closed;
        logic v_open;
        logic v_close;
        logic v_stop;
        logic v_reed_done;
        logic v_reed_check;
        tlgc_pkg::t_mode v_done_mode;

        n_mode     = r_mode;
        n_opening  = r_opening;
        n_closing  = r_closing;
        n_closed   = r_closed;
        n_run_a    = r_run_a;
        n_run_b    = r_run_b;
        n_dir      = r_dir;
        n_line_a   = r_line_a;
        n_line_b   = r_line_b;
        n_ind      = r_ind;
        n_active   = r_active;
        n_prescale = r_prescale;
        n_flash    = r_flash;
        n_travel   = r_travel;
        o_clr_push = 1'b0;

        v_push       = i_flags.push_seen | i_flags.remote_seen;
        v_closed     = i_flags.contact_a & i_flags.contact_b;
        v_open       = 1'b0;
        v_close      = 1'b0;
        v_stop       = 1'b0;
        v_reed_check = 1'b0;
        v_reed_done  = 1'b0;
        v_done_mode  = tlgc_pkg::MODE_IDLE;

        if (r_active) begin
            if (r_prescale < tlgc_pkg::PRESCALE_SAT) begin
                n_prescale = r_prescale + 4'd1;
            end
            if (n_prescale >= i_cfg.slow_tick_div) begin
                n_prescale = 4'd0;
                if (r_flash < tlgc_pkg::FLASH_SAT) begin
                    n_flash = r_flash + 3'd1;
                end
                if (n_flash >= i_cfg.flash_div) begin
                    n_ind   = ~r_ind;
                    n_flash = 3'd0;
                end
                if (r_travel != 8'd0) begin
                    n_travel = r_travel - 8'd1;
                end
            end
        end

        unique case (r_mode)
            tlgc_pkg::MODE_IDLE: begin
                n_closed = v_closed;
                if (v_push) begin
                    o_clr_push = 1'b1;
                    n_mode     = tlgc_pkg::MODE_RUN;
                    if (v_closed || r_closing) begin
                        v_open = 1'b1;
                    end else begin
                        v_close = 1'b1;
                    end
                end else if (i_flags.hold_seen) begin
                    n_mode = tlgc_pkg::MODE_MANUAL;
                    if (r_closing) begin
                        v_close = 1'b1;
                    end else if (r_opening || v_closed) begin
                        v_open = 1'b1;
                    end else begin
                        v_close = 1'b1;
                    end
                end
            end
            tlgc_pkg::MODE_RUN: begin
                if (i_flags.hold_seen) begin
                    v_stop = 1'b1;
                    n_mode = tlgc_pkg::MODE_WAIT;
                end else if (v_push) begin
                    o_clr_push = 1'b1;
                    v_stop     = 1'b1;
                    n_mode     = tlgc_pkg::MODE_IDLE;
                end else begin
                    v_reed_check = 1'b1;
                    v_done_mode  = tlgc_pkg::MODE_IDLE;
                end
            end
            tlgc_pkg::MODE_MANUAL: begin
                if (!i_flags.hold_seen) begin
                    v_stop = 1'b1;
                    n_mode = tlgc_pkg::MODE_IDLE;
                end else begin
                    v_reed_check = 1'b1;
                    v_done_mode  = tlgc_pkg::MODE_WAIT;
                end
            end
            tlgc_pkg::MODE_WAIT: begin
                if (!i_flags.hold_seen) begin
                    n_mode = tlgc_pkg::MODE_IDLE;
                end
            end
            default: begin
                n_mode = tlgc_pkg::MODE_IDLE;
            end
        endcase

        if (v_open) begin
            n_opening  = 1'b1;
            n_closing  = 1'b0;
            n_run_a    = 1'b1;
            n_run_b    = 1'b1;
            n_dir      = 1'b0;
            n_ind      = 1'b0;
            n_travel   = i_cfg.travel_limit;
            n_flash    = 3'd0;
            n_prescale = 4'd0;
            n_active   = 1'b1;
        end

        if (v_close) begin
            n_opening = 1'b0;
            if (!i_flags.contact_a) begin
                n_run_a = 1'b1;
            end
            if (!i_flags.contact_b) begin
                n_run_b = 1'b1;
            end
            if (n_run_a || n_run_b) begin
                n_dir      = 1'b1;
                n_ind      = 1'b1;
                n_travel   = i_cfg.travel_limit;
                n_flash    = 3'd0;
                n_prescale = 4'd0;
                n_active   = 1'b1;
                n_closing  = 1'b1;
            end else if (r_mode == tlgc_pkg::MODE_IDLE && v_push && !r_closing) begin
                n_mode = tlgc_pkg::MODE_IDLE;
            end
        end

        if (v_reed_check && r_closing) begin
            if (i_flags.contact_a) begin
                n_run_a  = 1'b0;
                n_line_a = 1'b0;
                if (!r_run_b) begin
                    n_mode      = v_done_mode;
                    n_active    = 1'b0;
                    v_reed_done = 1'b1;
                end
            end
            if (i_flags.contact_b && !v_reed_done) begin
                n_run_b  = 1'b0;
                n_line_b = 1'b0;
                if (!n_run_a) begin
                    n_mode      = v_done_mode;
                    n_active    = 1'b0;
                    v_reed_done = 1'b1;
                end
            end
        end

        if (v_reed_check && !v_reed_done && n_travel == 8'd0) begin
            v_stop = 1'b1;
            n_mode = v_done_mode;
        end

        if (v_stop) begin
            n_run_a  = 1'b0;
            n_run_b  = 1'b0;
            n_line_a = 1'b1;
            n_line_b = 1'b1;
            n_active = 1'b0;
        end
    end

    always_comb begin
        o_result.motor_a_on      = n_run_a;
        o_result.motor_b_on      = n_run_b;
        o_result.close_direction = n_dir;
        o_result.line_a          = n_line_a;
        o_result.line_b          = n_line_b;
        o_result.indicator       = n_ind;
        o_result.mode            = n_mode;
        o_result.gate_closed     = n_closed;
        o_result.is_opening      = n_opening;
        o_result.is_closing      = n_closing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= tlgc_pkg::MODE_IDLE;
            r_opening  <= 1'b0;
            r_closing  <= 1'b0;
            r_closed   <= 1'b0;
            r_run_a    <= 1'b0;
            r_run_b    <= 1'b0;
            r_dir      <= 1'b0;
            r_line_a   <= 1'b0;
            r_line_b   <= 1'b0;
            r_ind      <= 1'b0;
            r_active   <= 1'b0;
            r_prescale <= 4'd0;
            r_flash    <= 3'd0;
            r_travel   <= 8'd0;
        end else if (i_adv) begin
            r_mode     <= n_mode;
            r_opening  <= n_opening;
            r_closing  <= n_closing;
            r_closed   <= n_closed;
            r_run_a    <= n_run_a;
            r_run_b    <= n_run_b;
            r_dir      <= n_dir;
            r_line_a   <= n_line_a;
            r_line_b   <= n_line_b;
            r_ind      <= n_ind;
            r_active   <= n_active;
            r_prescale <= n_prescale;
            r_flash    <= n_flash;
            r_travel   <= n_travel;
        end
    end

    // In idle and wait no leaf motor may be driven.
    a_idle_motors_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == tlgc_pkg::MODE_IDLE || r_mode == tlgc_pkg::MODE_WAIT)
            |-> !(r_run_a || r_run_b))
        else $error("motor driven while idle or waiting");

    // The travel timer only runs while at least one motor is on.
    a_active_has_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_run_a || r_run_b))
        else $error("slow tick running with no motor on");

    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_opening && r_closing))
        else $error("opening and closing flagged together");

    // A push taken while running stops both leaves and returns to idle.
    a_push_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_clr_push && r_mode == tlgc_pkg::MODE_RUN)
            |=> (r_mode == tlgc_pkg::MODE_IDLE && !r_run_a && !r_run_b))
        else $error("push while running did not stop the leaves");

endmodule

### sv/two_leaf_gate_controller_top.sv
// A tick word is captured in the input register and then processed into the result register.
// Throughput: one tick word per clock cycle when not stalled; the result register is the only
// point where a downstream stall holds the input register and then the input.
// Reset (i_rst_n low, synchronous) clears all counters, flags and the mode to idle
// and loads the configuration registers with their default values.
// Top level: configuration registers, input and result registers, handshake.
module two_leaf_gate_controller_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_gate_button_level,
    input  logic                             i_remote_level,
    input  logic                             i_reed_a_level,
    input  logic                             i_reed_b_level,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_motor_a_on,
    output logic                             o_motor_b_on,
    output logic                             o_close_direction,
    output logic                             o_line_a,
    output logic                             o_line_b,
    output logic                             o_indicator,
    output logic [1:0]                       o_mode,
    output logic                             o_gate_closed,
    output logic                             o_is_opening,
    output logic                             o_is_closing,
    input  logic                             i_cfg_we,
    input  logic [tlgc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tlgc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    tlgc_pkg::t_cfg    r_cfg;
    logic              r_in_valid;
    logic [3:0]        r_in_levels;
    logic              r_out_valid;
    tlgc_pkg::t_result r_out;
    tlgc_pkg::t_result n_out;
    tlgc_pkg::t_deb    deb_flags;
    logic              clr_push;
    logic              adv;
    logic              in_take;

    assign adv     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !adv;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.push_min      <= tlgc_pkg::RST_PUSH_MIN;
            r_cfg.push_max      <= tlgc_pkg::RST_PUSH_MAX;
            r_cfg.hold_ticks    <= tlgc_pkg::RST_HOLD_TICKS;
            r_cfg.remote_min    <= tlgc_pkg::RST_REMOTE_MIN;
            r_cfg.contact_ticks <= tlgc_pkg::RST_CONTACT_TICKS;
            r_cfg.travel_limit  <= tlgc_pkg::RST_TRAVEL_LIMIT;
            r_cfg.slow_tick_div <= tlgc_pkg::RST_SLOW_TICK_DIV;
            r_cfg.flash_div     <= tlgc_pkg::RST_FLASH_DIV;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tlgc_pkg::CFG_PUSH_MIN:      r_cfg.push_min      <= i_cfg_data[7:0];
                tlgc_pkg::CFG_PUSH_MAX:      r_cfg.push_max      <= i_cfg_data[7:0];
                tlgc_pkg::CFG_HOLD_TICKS:    r_cfg.hold_ticks    <= i_cfg_data[7:0];
                tlgc_pkg::CFG_REMOTE_MIN:    r_cfg.remote_min    <= i_cfg_data[9:0];
                tlgc_pkg::CFG_CONTACT_TICKS: r_cfg.contact_ticks <= i_cfg_data[2:0];
                tlgc_pkg::CFG_TRAVEL_LIMIT:  r_cfg.travel_limit  <= i_cfg_data[7:0];
                tlgc_pkg::CFG_SLOW_TICK_DIV: r_cfg.slow_tick_div <= i_cfg_data[3:0];
                tlgc_pkg::CFG_FLASH_DIV:     r_cfg.flash_div     <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_levels <= {i_gate_button_level, i_remote_level,
                            i_reed_a_level, i_reed_b_level};
        end
    end

    tlgc_debounce u_debounce (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_cfg          (r_cfg),
        .i_button_level (r_in_levels[3]),
        .i_remote_level (r_in_levels[2]),
        .i_reed_a_level (r_in_levels[1]),
        .i_reed_b_level (r_in_levels[0]),
        .i_clr_push     (clr_push),
        .o_flags        (deb_flags)
    );

    tlgc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_cfg      (r_cfg),
        .i_flags    (deb_flags),
        .o_clr_push (clr_push),
        .o_result   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_motor_a_on      = r_out.motor_a_on;
    assign o_motor_b_on      = r_out.motor_b_on;
    assign o_close_direction = r_out.close_direction;
    assign o_line_a          = r_out.line_a;
    assign o_line_b          = r_out.line_b;
    assign o_indicator       = r_out.indicator;
    assign o_mode            = r_out.mode;
    assign o_gate_closed     = r_out.gate_closed;
    assign o_is_opening      = r_out.is_opening;
    assign o_is_closing      = r_out.is_closing;

    // A word is only processed when the result register can take it.
    a_adv_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |-> (!r_out_valid || !i_stall))
        else $error("word processed over a stalled result");

    // A held result word stays valid while the output is stalled.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("stalled result word dropped");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in_levels)))
        else $error("waiting input word lost");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-leaf gate controller: tick words are sent with random
// gaps and stalls over several configuration phases, and each result word is checked.
// Depends on tlgc_pkg and two_leaf_gate_controller_top.
module tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_OFF    = 200;

    typedef struct packed {
        logic button;
        logic remote;
        logic reed_a;
        logic reed_b;
    } t_tick;

    class gate_scoreboard;
        tlgc_pkg::t_cfg    cfg;
        logic [7:0]        press_cnt;
        logic [9:0]        remote_cnt;
        logic [2:0]        reed_a_cnt;
        logic [2:0]        reed_b_cnt;
        logic              push_seen, hold_seen, remote_seen, contact_a, contact_b;
        tlgc_pkg::t_mode   mode_r;
        logic              mv_opening, mv_closing, mv_closed;
        logic              run_a, run_b;
        logic              dir_close, line_a, line_b, ind;
        logic              mover_on;
        logic [3:0]        prescale;
        logic [2:0]        flash;
        logic [7:0]        travel;
        tlgc_pkg::t_result pending_results[$];
        int                errors;

        function new();
            cfg.push_min      = tlgc_pkg::RST_PUSH_MIN;
            cfg.push_max      = tlgc_pkg::RST_PUSH_MAX;
            cfg.hold_ticks    = tlgc_pkg::RST_HOLD_TICKS;
            cfg.remote_min    = tlgc_pkg::RST_REMOTE_MIN;
            cfg.contact_ticks = tlgc_pkg::RST_CONTACT_TICKS;
            cfg.travel_limit  = tlgc_pkg::RST_TRAVEL_LIMIT;
            cfg.slow_tick_div = tlgc_pkg::RST_SLOW_TICK_DIV;
            cfg.flash_div     = tlgc_pkg::RST_FLASH_DIV;
            press_cnt = '0;
            remote_cnt = '0;
            reed_a_cnt = '0;
            reed_b_cnt = '0;
            {push_seen, hold_seen, remote_seen, contact_a, contact_b} = '0;
            mode_r = tlgc_pkg::MODE_IDLE;
            {mv_opening, mv_closing, mv_closed, run_a, run_b} = '0;
            {dir_close, line_a, line_b, ind, mover_on} = '0;
            prescale = '0;
            flash = '0;
            travel = '0;
            errors = 0;
        endfunction

        function void set_cfg(logic [tlgc_pkg::CFG_INDEX_W-1:0] idx,
                              logic [tlgc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tlgc_pkg::CFG_PUSH_MIN:      cfg.push_min      = data[7:0];
                tlgc_pkg::CFG_PUSH_MAX:      cfg.push_max      = data[7:0];
                tlgc_pkg::CFG_HOLD_TICKS:    cfg.hold_ticks    = data[7:0];
                tlgc_pkg::CFG_REMOTE_MIN:    cfg.remote_min    = data[9:0];
                tlgc_pkg::CFG_CONTACT_TICKS: cfg.contact_ticks = data[2:0];
                tlgc_pkg::CFG_TRAVEL_LIMIT:  cfg.travel_limit  = data[7:0];
                tlgc_pkg::CFG_SLOW_TICK_DIV: cfg.slow_tick_div = data[3:0];
                tlgc_pkg::CFG_FLASH_DIV:     cfg.flash_div     = data[2:0];
                default: ;
            endcase
        endfunction

        function void reed_debounce(logic closed, inout logic [2:0] cnt, inout logic valid);
            if (closed) begin
                if (cnt < cfg.contact_ticks) begin
                    cnt++;
                    if (cnt == cfg.contact_ticks) valid = 1'b1;
                end
            end else begin
                valid = 1'b0;
                cnt = '0;
            end
        endfunction

        function void start_mover(logic closing);
            dir_close = closing;
            ind = closing;
            travel = cfg.travel_limit;
            flash = '0;
            prescale = '0;
            mover_on = 1'b1;
        endfunction

        function void open_leaves();
            mv_opening = 1'b1;
            mv_closing = 1'b0;
            run_a = 1'b1;
            run_b = 1'b1;
            start_mover(1'b0);
        endfunction

        function void close_leaves();
            mv_opening = 1'b0;
            if (!contact_a) run_a = 1'b1;
            if (!contact_b) run_b = 1'b1;
            if (run_a || run_b) begin
                start_mover(1'b1);
                mv_closing = 1'b1;
            end
        endfunction

        function void stop_leaves();
            run_a = 1'b0;
            run_b = 1'b0;
            line_a = 1'b1;
            line_b = 1'b1;
            mover_on = 1'b0;
        endfunction

        // Returns 1 when a reed contact has ended the closing run.
        function logic reed_stop(tlgc_pkg::t_mode done_mode);
            if (!mv_closing) return 1'b0;
            if (contact_a) begin
                run_a = 1'b0;
                line_a = 1'b0;
                if (!run_b) begin
                    mode_r = done_mode;
                    mover_on = 1'b0;
                    return 1'b1;
                end
            end
            if (contact_b) begin
                run_b = 1'b0;
                line_b = 1'b0;
                if (!run_a) begin
                    mode_r = done_mode;
                    mover_on = 1'b0;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_tick(t_tick t);
            tlgc_pkg::t_result r;
            logic              closed;
            if (!t.button) begin
                if (press_cnt < cfg.hold_ticks) press_cnt++;
                if (press_cnt == cfg.hold_ticks) hold_seen = 1'b1;
            end else begin
                if (press_cnt > cfg.push_min && press_cnt < cfg.push_max) push_seen = 1'b1;
                else hold_seen = 1'b0;
                press_cnt = '0;
            end
            if (!t.remote) begin
                if (remote_cnt < tlgc_pkg::REMOTE_SAT) remote_cnt++;
            end else begin
                if (remote_cnt > cfg.remote_min) remote_seen = 1'b1;
                remote_cnt = '0;
            end
            reed_debounce(!t.reed_a, reed_a_cnt, contact_a);
            reed_debounce(!t.reed_b, reed_b_cnt, contact_b);

            if (mover_on) begin
                if (prescale < tlgc_pkg::PRESCALE_SAT) prescale++;
                if (prescale >= cfg.slow_tick_div) begin
                    prescale = '0;
                    if (flash < tlgc_pkg::FLASH_SAT) flash++;
                    if (flash >= cfg.flash_div) begin
                        ind = ~ind;
                        flash = '0;
                    end
                    if (travel != 0) travel--;
                end
            end

            case (mode_r)
                tlgc_pkg::MODE_IDLE: begin
                    closed = contact_a && contact_b;
                    mv_closed = closed;
                    if (push_seen || remote_seen) begin
                        push_seen = 1'b0;
                        remote_seen = 1'b0;
                        mode_r = tlgc_pkg::MODE_RUN;
                        if (closed || mv_closing) begin
                            open_leaves();
                        end else begin
                            close_leaves();
                            if (!mv_closing) mode_r = tlgc_pkg::MODE_IDLE;
                        end
                    end else if (hold_seen) begin
                        mode_r = tlgc_pkg::MODE_MANUAL;
                        if (mv_closing) close_leaves();
                        else if (mv_opening) open_leaves();
                        else if (closed) open_leaves();
                        else close_leaves();
                    end
                end
                tlgc_pkg::MODE_RUN: begin
                    if (hold_seen) begin
                        stop_leaves();
                        mode_r = tlgc_pkg::MODE_WAIT;
                    end else if (push_seen || remote_seen) begin
                        push_seen = 1'b0;
                        remote_seen = 1'b0;
                        stop_leaves();
                        mode_r = tlgc_pkg::MODE_IDLE;
                    end else if (!reed_stop(tlgc_pkg::MODE_IDLE) && travel == 0) begin
                        stop_leaves();
                        if (hold_seen) mode_r = tlgc_pkg::MODE_WAIT;
                        else mode_r = tlgc_pkg::MODE_IDLE;
                    end
                end
                tlgc_pkg::MODE_MANUAL: begin
                    if (!hold_seen) begin
                        stop_leaves();
                        mode_r = tlgc_pkg::MODE_IDLE;
                    end else if (!reed_stop(tlgc_pkg::MODE_WAIT) && travel == 0) begin
                        stop_leaves();
                        mode_r = tlgc_pkg::MODE_WAIT;
                    end
                end
                default: begin
                    if (!hold_seen) mode_r = tlgc_pkg::MODE_IDLE;
                end
            endcase

            r.motor_a_on      = run_a;
            r.motor_b_on      = run_b;
            r.close_direction = dir_close;
            r.line_a          = line_a;
            r.line_b          = line_b;
            r.indicator       = ind;
            r.mode            = mode_r;
            r.gate_closed     = mv_closed;
            r.is_opening      = mv_opening;
            r.is_closing      = mv_closing;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [1:0] want, logic [1:0] got);
            if (got !== want) begin
                errors++;
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        function void check_result(tlgc_pkg::t_result got);
            tlgc_pkg::t_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $error("result word arrived with nothing expected");
                return;
            end
            want = pending_results.pop_front();
            compare_field("motor_a_on", {1'b0, want.motor_a_on}, {1'b0, got.motor_a_on});
            compare_field("motor_b_on", {1'b0, want.motor_b_on}, {1'b0, got.motor_b_on});
            compare_field("close_direction", {1'b0, want.close_direction},
                          {1'b0, got.close_direction});
            compare_field("line_a", {1'b0, want.line_a}, {1'b0, got.line_a});
            compare_field("line_b", {1'b0, want.line_b}, {1'b0, got.line_b});
            compare_field("indicator", {1'b0, want.indicator}, {1'b0, got.indicator});
            compare_field("mode", want.mode, got.mode);
            compare_field("gate_closed", {1'b0, want.gate_closed}, {1'b0, got.gate_closed});
            compare_field("is_opening", {1'b0, want.is_opening}, {1'b0, got.is_opening});
            compare_field("is_closing", {1'b0, want.is_closing}, {1'b0, got.is_closing});
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_stall;
    logic                             i_gate_button_level;
    logic                             i_remote_level;
    logic                             i_reed_a_level;
    logic                             i_reed_b_level;
    logic                             o_valid;
    logic                             i_stall;
    logic                             o_motor_a_on;
    logic                             o_motor_b_on;
    logic                             o_close_direction;
    logic                             o_line_a;
    logic                             o_line_b;
    logic                             o_indicator;
    logic [1:0]                       o_mode;
    logic                             o_gate_closed;
    logic                             o_is_opening;
    logic                             o_is_closing;
    logic                             i_cfg_we;
    logic [tlgc_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [tlgc_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    gate_scoreboard sb;
    logic rst_done        = 1'b0;
    logic calm            = 1'b0;
    logic pressure_req    = 1'b0;
    logic pressure_served = 1'b0;
    logic reed_a_lvl      = 1'b1;
    logic reed_b_lvl      = 1'b1;
    int   ticks_sent      = 0;
    int   cycle_count     = 0;

    two_leaf_gate_controller_top DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_gate_button_level (i_gate_button_level),
        .i_remote_level      (i_remote_level),
        .i_reed_a_level      (i_reed_a_level),
        .i_reed_b_level      (i_reed_b_level),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_motor_a_on        (o_motor_a_on),
        .o_motor_b_on        (o_motor_b_on),
        .o_close_direction   (o_close_direction),
        .o_line_a            (o_line_a),
        .o_line_b            (o_line_b),
        .o_indicator         (o_indicator),
        .o_mode              (o_mode),
        .o_gate_closed       (o_gate_closed),
        .o_is_opening        (o_is_opening),
        .o_is_closing        (o_is_closing),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_motor_a_on, o_motor_b_on, o_close_direction, o_line_a, o_line_b,
                             o_indicator, o_mode, o_gate_closed, o_is_opening, o_is_closing});
    end

    initial begin
        int span;
        i_stall <= 1'b0;
        wait (rst_done);
        forever begin
            if (pressure_req && !pressure_served) begin
                pressure_served = 1'b1;
                i_stall <= 1'b1;
                span = HOLD_OFF;
            end else if (calm || $urandom_range(3, 0) != 0) begin
                i_stall <= 1'b0;
                span = $urandom_range(20, 1);
            end else begin
                i_stall <= 1'b1;
                span = $urandom_range(10, 1);
            end
            repeat (span) @(posedge i_clk);
        end
    end

    task automatic send_tick(input t_tick t);
        if (!calm && $urandom_range(4, 0) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(10, 1)) @(posedge i_clk);
        end
        i_gate_button_level <= t.button;
        i_remote_level      <= t.remote;
        i_reed_a_level      <= t.reed_a;
        i_reed_b_level      <= t.reed_b;
        i_valid             <= 1'b1;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        sb.note_tick(t);
        ticks_sent++;
    endtask

    task automatic send_run(input int n, input t_tick t);
        repeat (n) send_tick(t);
    endtask

    // The reed levels drift on their own so that contacts make and break during movement.
    task automatic send_span(input int n, input logic btn, input logic rem);
        t_tick t;
        repeat (n) begin
            if ($urandom_range(23, 0) == 0) reed_a_lvl = ~reed_a_lvl;
            if ($urandom_range(23, 0) == 0) reed_b_lvl = ~reed_b_lvl;
            t.button = btn;
            t.remote = rem;
            t.reed_a = reed_a_lvl;
            t.reed_b = reed_b_lvl;
            send_tick(t);
        end
    endtask

    task automatic random_segment();
        int    kind;
        int    len;
        int    lo;
        int    hi;
        t_tick t;
        kind = $urandom_range(99, 0);
        if (kind < 35) begin
            lo = sb.cfg.push_min + 1;
            hi = sb.cfg.push_max - 1;
            if (hi >= lo) len = $urandom_range(hi, lo);
            else len = $urandom_range(20, 1);
            send_span(len, 1'b0, 1'b1);
            send_span($urandom_range(6, 1), 1'b1, 1'b1);
        end else if (kind < 50) begin
            len = sb.cfg.hold_ticks + $urandom_range(8, 0);
            if (len > 300) len = $urandom_range(20, 1);
            send_span(len, 1'b0, 1'b1);
            send_span($urandom_range(6, 1), 1'b1, 1'b1);
        end else if (kind < 70) begin
            len = sb.cfg.remote_min + $urandom_range(4, 1);
            if (len > 300) len = $urandom_range(20, 1);
            send_span(len, 1'b1, 1'b0);
            send_span($urandom_range(6, 1), 1'b1, 1'b1);
        end else if (kind < 83) begin
            send_span($urandom_range(40, 1), 1'b1, 1'b1);
        end else if (kind < 93) begin
            repeat ($urandom_range(10, 1)) begin
                t = t_tick'(4'($urandom_range(15, 0)));
                send_tick(t);
            end
        end else begin
            if ($urandom_range(1, 0) == 0) len = $urandom_range(sb.cfg.push_min, 0);
            else len = sb.cfg.push_max + $urandom_range(3, 0);
            if (len > 300) len = $urandom_range(20, 1);
            send_span(len, 1'b0, 1'($urandom_range(1, 0)));
            send_span($urandom_range(6, 1), 1'b1, 1'b1);
        end
    endtask

    task automatic random_run(input int n);
        int start;
        start = ticks_sent;
        while (ticks_sent - start < n) random_segment();
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [tlgc_pkg::CFG_INDEX_W-1:0] idx, input int data);
        logic [tlgc_pkg::CFG_DATA_W-1:0] value;
        value = data[tlgc_pkg::CFG_DATA_W-1:0];
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.set_cfg(idx, value);
    endtask

    task automatic apply_cfg(input int pmin, input int pmax, input int hold, input int rmin,
                             input int contact, input int travel, input int sdiv,
                             input int fdiv);
        cfg_write(tlgc_pkg::CFG_PUSH_MIN, pmin);
        cfg_write(tlgc_pkg::CFG_PUSH_MAX, pmax);
        cfg_write(tlgc_pkg::CFG_HOLD_TICKS, hold);
        cfg_write(tlgc_pkg::CFG_REMOTE_MIN, rmin);
        cfg_write(tlgc_pkg::CFG_CONTACT_TICKS, contact);
        cfg_write(tlgc_pkg::CFG_TRAVEL_LIMIT, travel);
        cfg_write(tlgc_pkg::CFG_SLOW_TICK_DIV, sdiv);
        cfg_write(tlgc_pkg::CFG_FLASH_DIV, fdiv);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int pmin;
        int pmax;
        sb = new();
        i_rst_n             <= 1'b0;
        i_valid             <= 1'b0;
        i_gate_button_level <= 1'b1;
        i_remote_level      <= 1'b1;
        i_reed_a_level      <= 1'b1;
        i_reed_b_level      <= 1'b1;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= tlgc_pkg::CFG_PUSH_MIN;
        i_cfg_data          <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        // Short thresholds so that each word of the opening sequence has a clear effect.
        apply_cfg(1, 4, 6, 1, 1, 3, 1, 1);
        send_run(1, 4'b1111);
        send_run(2, 4'b0111);
        send_run(1, 4'b1111);
        send_run(2, 4'b1101);
        send_run(2, 4'b1100);
        send_run(1, 4'b1100);
        send_run(2, 4'b1000);
        send_run(1, 4'b1100);
        send_run(3, 4'b1111);
        send_run(7, 4'b0111);
        send_run(1, 4'b1111);
        send_run(1, 4'b0000);
        send_run(1, 4'b1111);
        random_run(200);

        settle();
        apply_cfg(2, 9, 14, 3, 3, 12, 2, 3);
        pressure_req = 1'b1;
        random_run(350);

        settle();
        apply_cfg(tlgc_pkg::RST_PUSH_MIN, tlgc_pkg::RST_PUSH_MAX, tlgc_pkg::RST_HOLD_TICKS,
                  tlgc_pkg::RST_REMOTE_MIN, tlgc_pkg::RST_CONTACT_TICKS,
                  tlgc_pkg::RST_TRAVEL_LIMIT, tlgc_pkg::RST_SLOW_TICK_DIV,
                  tlgc_pkg::RST_FLASH_DIV);
        random_run(150);

        settle();
        apply_cfg(0, 0, 1, 0, 1, 1, 1, 1);
        random_run(150);

        settle();
        apply_cfg(0, 255, 0, 1023, 0, 0, 0, 0);
        random_run(120);

        settle();
        apply_cfg(255, 255, 255, 999, 7, 255, 15, 7);
        random_run(330);

        for (int k = 0; k < 2; k++) begin
            settle();
            pmin = $urandom_range(4, 0);
            pmax = pmin + $urandom_range(8, 2);
            apply_cfg(pmin, pmax, pmax + $urandom_range(6, 0), $urandom_range(6, 0),
                      $urandom_range(7, 1), $urandom_range(20, 1), $urandom_range(4, 1),
                      $urandom_range(7, 1));
            if (k == 1) calm = 1'b1;
            random_run(275);
        end

        settle();
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
